// ===== hw/rtl/hpt_pkg.sv =====
package hpt_pkg;

  localparam int unsigned ASID_W     = 6;
  localparam int unsigned VPN_W      = 20;
  localparam int unsigned PPN_W      = 20;
  localparam int unsigned SLOT_W     = 10;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned PAGE_SHIFT = 12;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_ZERO = 2'd2,
    ST_FULL = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_READ,
    S_CHECK,
    S_REJECT
  } state_e;

  // one table entry, 48 bits
  typedef struct packed {
    logic              valid;
    logic [ASID_W-1:0] asid;
    logic [VPN_W-1:0]  vpn;
    logic [PPN_W-1:0]  ppn;
    logic              dirty;
  } entry_t;

  typedef struct packed {
    op_e               opcode;
    logic [ASID_W-1:0] asid;
    logic [VPN_W-1:0]  vpn;
    logic [PPN_W-1:0]  ppn;
    logic              writable;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [SLOT_W-1:0] slot;
    logic [WORD_W-1:0] tlb_hi;
    logic [WORD_W-1:0] tlb_lo;
  } rsp_t;

  // tlb words for a stored entry: uncached bit 11, dirty bit 10, valid bit 9
  function automatic rsp_t make_hit(logic [SLOT_W-1:0] slot, entry_t e);
    rsp_t r;
    r.status = ST_OK;
    r.slot   = slot;
    r.tlb_hi = {e.vpn, {PAGE_SHIFT{1'b0}}};
    r.tlb_lo = {e.ppn, 1'b1, e.dirty, 1'b1, {(PAGE_SHIFT - 3){1'b0}}};
    return r;
  endfunction

  function automatic rsp_t make_fail(status_e status);
    rsp_t r;
    r.status = status;
    r.slot   = '0;
    r.tlb_hi = '0;
    r.tlb_lo = '0;
    return r;
  endfunction

endpackage

// ===== hw/rtl/hpt_req_if.sv =====
interface hpt_req_if import hpt_pkg::*;;
  logic              valid;
  logic              ready;
  op_e               opcode;
  logic [ASID_W-1:0] asid;
  logic [VPN_W-1:0]  vpn;
  logic [PPN_W-1:0]  ppn;
  logic              writable;

  modport source (output valid, opcode, asid, vpn, ppn, writable, input ready);
  modport sink   (input valid, opcode, asid, vpn, ppn, writable, output ready);
endinterface

// ===== hw/rtl/hpt_rsp_if.sv =====
interface hpt_rsp_if import hpt_pkg::*;;
  logic              valid;
  logic              ready;
  status_e           status;
  logic [SLOT_W-1:0] slot;
  logic [WORD_W-1:0] tlb_hi;
  logic [WORD_W-1:0] tlb_lo;

  modport source (output valid, status, slot, tlb_hi, tlb_lo, input ready);
  modport sink   (input valid, status, slot, tlb_hi, tlb_lo, output ready);
endinterface

// ===== hw/rtl/hpt_hash.sv =====
module hpt_hash import hpt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 1024,
  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [VPN_W-1:0] key_i,
  output logic             done_o,
  output logic [IDX_W-1:0] idx_o
);

  // key mod depth by reciprocal multiply, exact for every 20-bit key
  localparam int unsigned SHIFT  = VPN_W + IDX_W;
  localparam int unsigned MUL_W  = VPN_W + 2;
  localparam int unsigned PROD_W = VPN_W + MUL_W;
  localparam longint unsigned MUL_L =
    ((64'd1 << SHIFT) + 64'(TABLE_DEPTH) - 64'd1) / 64'(TABLE_DEPTH);
  localparam logic [MUL_W-1:0] MUL = MUL_W'(MUL_L);
  localparam int unsigned DEP_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned QD_W  = VPN_W + DEP_W;
  localparam logic [DEP_W-1:0] DEP = DEP_W'(TABLE_DEPTH);

  logic [2:0]        vld_q;
  logic [PROD_W-1:0] prod_q;
  logic [VPN_W-1:0]  key1_q, key2_q;
  logic [QD_W-1:0]   qd_q;
  logic [IDX_W-1:0]  idx_q;
  logic [VPN_W-1:0]  quot, rem;

  assign quot = VPN_W'(prod_q >> SHIFT);
  assign rem  = key2_q - VPN_W'(qd_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(key_i) * PROD_W'(MUL);
    key1_q <= key_i;
    qd_q   <= QD_W'(quot) * QD_W'(DEP);
    key2_q <= key1_q;
    idx_q  <= IDX_W'(rem);
  end

  assign done_o = vld_q[2];
  assign idx_o  = idx_q;

endmodule

// ===== hw/rtl/hpt_ram.sv =====
module hpt_ram import hpt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 1024,
  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  entry_t           wdata_i,
  input  logic             re_i,
  input  logic [IDX_W-1:0] raddr_i,
  output entry_t           rdata_o
);

  entry_t mem_q [TABLE_DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/hpt_probe.sv =====
module hpt_probe import hpt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 1024,
  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  input  req_t             req_i,
  output logic             req_ready_o,
  output logic             hash_start_o,
  output logic [VPN_W-1:0] hash_key_o,
  input  logic             hash_done_i,
  input  logic [IDX_W-1:0] hash_idx_i,
  output logic             ram_we_o,
  output logic [IDX_W-1:0] ram_waddr_o,
  output entry_t           ram_wdata_o,
  output logic             ram_re_o,
  output logic [IDX_W-1:0] ram_raddr_o,
  input  entry_t           ram_rdata_i,
  input  logic             res_busy_i,
  output logic             res_push_o,
  output rsp_t             res_o
);

  localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_DEPTH - 1);

  state_e           state_q, state_d;
  req_t             item_q, item_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [IDX_W-1:0] n_q, n_d;
  logic [IDX_W-1:0] idx_inc;
  entry_t           new_entry;

  assign idx_inc = (idx_q == LAST) ? '0 : idx_q + 1'b1;

  always_comb begin
    new_entry.valid = 1'b1;
    new_entry.asid  = item_q.asid;
    new_entry.vpn   = item_q.vpn;
    new_entry.ppn   = item_q.ppn;
    new_entry.dirty = item_q.writable;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      idx_q   <= '0;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      n_q     <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    idx_d        = idx_q;
    n_d          = n_q;
    req_ready_o  = 1'b0;
    hash_start_o = 1'b0;
    hash_key_o   = VPN_W'(req_i.asid) ^ req_i.vpn;
    ram_we_o     = 1'b0;
    ram_waddr_o  = idx_q;
    ram_wdata_o  = new_entry;
    ram_re_o     = 1'b0;
    ram_raddr_o  = idx_q;
    res_push_o   = 1'b0;
    res_o        = make_fail(ST_MISS);

    case (state_q)
      S_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_wdata_o = '0;
        idx_d       = idx_inc;
        if (idx_q == LAST) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          item_d = req_i;
          if (req_i.opcode == OP_INSERT && (req_i.vpn == '0 || req_i.ppn == '0)) begin
            state_d = S_REJECT;
          end else begin
            hash_start_o = 1'b1;
            state_d      = S_HASH;
          end
        end
      end
      S_HASH: begin
        if (hash_done_i) begin
          idx_d   = hash_idx_i;
          n_d     = '0;
          state_d = S_READ;
        end
      end
      S_READ: begin
        ram_re_o = 1'b1;
        state_d  = S_CHECK;
      end
      S_CHECK: begin
        if (!res_busy_i) begin
          if (!ram_rdata_i.valid) begin
            res_push_o = 1'b1;
            state_d    = S_IDLE;
            if (item_q.opcode == OP_INSERT) begin
              ram_we_o = 1'b1;
              res_o    = make_hit(SLOT_W'(idx_q), new_entry);
            end
          end else if (item_q.opcode == OP_LOOKUP && ram_rdata_i.asid == item_q.asid
                       && ram_rdata_i.vpn == item_q.vpn) begin
            res_push_o = 1'b1;
            res_o      = make_hit(SLOT_W'(idx_q), ram_rdata_i);
            state_d    = S_IDLE;
          end else if (n_q == LAST) begin
            // every slot visited
            res_push_o = 1'b1;
            res_o      = make_fail(item_q.opcode == OP_INSERT ? ST_FULL : ST_MISS);
            state_d    = S_IDLE;
          end else begin
            ram_re_o    = 1'b1;
            ram_raddr_o = idx_inc;
            idx_d       = idx_inc;
            n_d         = n_q + 1'b1;
          end
        end
      end
      S_REJECT: begin
        if (!res_busy_i) begin
          res_push_o = 1'b1;
          res_o      = make_fail(ST_ZERO);
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/hashed_page_table.sv =====
// a lookup or insert runs through the hash pipeline (product, quotient times depth,
// remainder), one ram read, then one check per slot probed, stalled by a busy output
// one item at a time, none taken until its result is pushed; a zero-page insert
// skips the hash; the probe loop is bound by the single read port of the entry ram
// reset: after rst_ni rises the table is cleared one entry a cycle,
// with ready low until done
module hashed_page_table import hpt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  hpt_req_if.sink   req_i,
  hpt_rsp_if.source rsp_o
);

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);

  req_t             req;
  logic             hash_start;
  logic [VPN_W-1:0] hash_key;
  logic             hash_done;
  logic [IDX_W-1:0] hash_idx;
  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  entry_t           ram_wdata, ram_rdata;
  logic             res_busy, res_push;
  rsp_t             res;
  logic             out_valid_q, out_valid_d;
  rsp_t             out_q;

  always_comb begin
    req.opcode   = req_i.opcode;
    req.asid     = req_i.asid;
    req.vpn      = req_i.vpn;
    req.ppn      = req_i.ppn;
    req.writable = req_i.writable;
  end

  hpt_hash #(.TABLE_DEPTH(TABLE_DEPTH)) u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start),
    .key_i   (hash_key),
    .done_o  (hash_done),
    .idx_o   (hash_idx)
  );

  hpt_ram #(.TABLE_DEPTH(TABLE_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  hpt_probe #(.TABLE_DEPTH(TABLE_DEPTH)) u_probe (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_i.valid),
    .req_i        (req),
    .req_ready_o  (req_i.ready),
    .hash_start_o (hash_start),
    .hash_key_o   (hash_key),
    .hash_done_i  (hash_done),
    .hash_idx_i   (hash_idx),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata),
    .res_busy_i   (res_busy),
    .res_push_o   (res_push),
    .res_o        (res)
  );

  // output register, new result only when the old one is gone or leaving
  assign res_busy    = out_valid_q && !rsp_o.ready;
  assign out_valid_d = res_push || res_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.status = out_q.status;
  assign rsp_o.slot   = out_q.slot;
  assign rsp_o.tlb_hi = out_q.tlb_hi;
  assign rsp_o.tlb_lo = out_q.tlb_lo;

endmodule

// ===== hw/rtl/hpt_checker.sv =====
module hpt_checker import hpt_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              req_valid_i,
  input logic              req_ready_i,
  input logic              rsp_valid_i,
  input logic              rsp_ready_i,
  input status_e           rsp_status_i,
  input logic [SLOT_W-1:0] rsp_slot_i,
  input logic [WORD_W-1:0] rsp_tlb_hi_i,
  input logic [WORD_W-1:0] rsp_tlb_lo_i
);

  // one item in flight: no new item right after one is taken
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("item accepted while another is in flight");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i != ST_OK |->
      rsp_slot_i == '0 && rsp_tlb_hi_i == '0 && rsp_tlb_lo_i == '0)
    else $error("failed result carries nonzero fields");

  // a hit always shows uncached and valid, never vpn zero
  a_hit_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i == ST_OK |->
      rsp_tlb_lo_i[11] && rsp_tlb_lo_i[9] && rsp_tlb_lo_i[8:0] == '0
      && rsp_tlb_hi_i[11:0] == '0 && rsp_tlb_hi_i != '0 && rsp_tlb_lo_i[31:12] != '0)
    else $error("malformed tlb words on hit");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i)
      && $stable(rsp_slot_i) && $stable(rsp_tlb_hi_i) && $stable(rsp_tlb_lo_i))
    else $error("stalled result changed");

endmodule

bind hashed_page_table hpt_checker u_hpt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_slot_i   (rsp_o.slot),
  .rsp_tlb_hi_i (rsp_o.tlb_hi),
  .rsp_tlb_lo_i (rsp_o.tlb_lo)
);
